@@ design/tpbd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpbd_pkg
// Shared types and constants for the tick prescaler and button debouncer.
// ----------------------------------------------------------------------------
package tpbd_pkg;

   localparam int CFG_WIDTH      = 8;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int NUM_BUTTONS    = 3;
   localparam int COUNT_WIDTH_DEF = 8;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [CFG_WIDTH-1:0] SECOND_RELOAD_RST   = 8'd45;
   localparam logic [CFG_WIDTH-1:0] FAST_RELOAD_RST     = 8'd2;
   localparam logic [CFG_WIDTH-1:0] COUNT_LIMIT_RST     = 8'd200;
   localparam logic [CFG_WIDTH-1:0] PRESS_THRESHOLD_RST = 8'd25;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_SECOND_RELOAD   = 2'd0,
      REG_FAST_RELOAD     = 2'd1,
      REG_COUNT_LIMIT     = 2'd2,
      REG_PRESS_THRESHOLD = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] second_reload;
      logic [CFG_WIDTH-1:0] fast_reload;
      logic [CFG_WIDTH-1:0] count_limit;
      logic [CFG_WIDTH-1:0] press_threshold;
   } cfg_type;

endpackage

@@ design/tpbd_csr.sv @@
// ----------------------------------------------------------------------------
// tpbd_csr
// Configuration register file, written through the csr channel.
// ----------------------------------------------------------------------------
module tpbd_csr
   import tpbd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SECOND_RELOAD:   cfg_in.second_reload   = csr_data;
            REG_FAST_RELOAD:     cfg_in.fast_reload     = csr_data;
            REG_COUNT_LIMIT:     cfg_in.count_limit     = csr_data;
            REG_PRESS_THRESHOLD: cfg_in.press_threshold = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.second_reload   <= SECOND_RELOAD_RST;
         cfg_ff.fast_reload     <= FAST_RELOAD_RST;
         cfg_ff.count_limit     <= COUNT_LIMIT_RST;
         cfg_ff.press_threshold <= PRESS_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/tpbd_prescaler.sv @@
// ----------------------------------------------------------------------------
// tpbd_prescaler
// Down-counting prescaler, fires and reloads when the count reaches one or zero.
// ----------------------------------------------------------------------------
module tpbd_prescaler
   import tpbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [CFG_WIDTH-1:0] reload,
   output logic                 fire
);

   logic [CFG_WIDTH-1:0] count_ff;
   logic [CFG_WIDTH-1:0] count_in;

   always_comb begin
      fire     = (count_ff <= CFG_WIDTH'(1));
      count_in = fire ? reload : (count_ff - CFG_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

endmodule

@@ design/tpbd_debounce.sv @@
// ----------------------------------------------------------------------------
// tpbd_debounce
// Integrating debouncer for one button, set above threshold, clear at zero.
// ----------------------------------------------------------------------------
module tpbd_debounce
   import tpbd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 level,
   input  logic [CFG_WIDTH-1:0] count_limit,
   input  logic [CFG_WIDTH-1:0] press_threshold,
   output logic                 mark_next
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   mark_ff;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [CMP_WIDTH-1:0]   count_ext;
   logic [CMP_WIDTH-1:0]   inc_ext;
   logic [CMP_WIDTH-1:0]   limit_ext;
   logic [CMP_WIDTH-1:0]   thresh_ext;

   always_comb begin
      count_inc  = count_ff + COUNT_WIDTH'(1);
      count_dec  = (count_ff != '0) ? (count_ff - COUNT_WIDTH'(1)) : '0;
      count_ext  = CMP_WIDTH'(count_ff);
      inc_ext    = CMP_WIDTH'(count_inc);
      limit_ext  = CMP_WIDTH'(count_limit);
      thresh_ext = CMP_WIDTH'(press_threshold);
      count_in   = count_ff;
      mark_next  = mark_ff;
      if (level) begin
         if ((count_ext < limit_ext) && (count_ff != '1)) begin
            count_in = count_inc;
            if (inc_ext > thresh_ext) begin
               mark_next = 1'b1;
            end
         end
      end else begin
         count_in = count_dec;
         if (count_dec == '0) begin
            mark_next = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mark_ff  <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         mark_ff  <= mark_next;
      end
   end

endmodule

@@ design/tick_prescaler_and_button_debounce_core.sv @@
// ----------------------------------------------------------------------------
// tick_prescaler_and_button_debounce_core
// Two tick prescalers and three integrating button debouncers.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_tvalid/tready     req_tdata  (button levels)
//  rsp_     out        rsp_tvalid/tready     rsp_tdata  (events, pressed marks)
//  csr_     in         csr_valid/csr_ready   csr_index, csr_data
//
//  one request per cycle while the response is not stalled; a request passes
//  the input register, then the state update into the response register
//  synchronous reset restores register defaults and clears all counters
//  a stalled response holds while one more request waits in the input register
// ----------------------------------------------------------------------------
module tick_prescaler_and_button_debounce_core
   import tpbd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [0] button_one, [1] button_two, [2] button_three
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] slow_event, [1] fast_event, [2] pressed_one, [3] pressed_two,
   // [4] pressed_three
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CFG_WIDTH-1:0]      csr_data
);

   cfg_type                cfg;
   logic                   in_valid_ff;
   logic [NUM_BUTTONS-1:0] in_buttons_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff;
   logic [RSP_DATA_WIDTH-1:0] out_data_in;
   logic                   out_free;
   logic                   step;
   logic                   slow_fire;
   logic                   fast_fire;
   logic [NUM_BUTTONS-1:0] mark_next;

   assign csr_ready = 1'b1;

   tpbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_buttons_ff <= req_tdata[NUM_BUTTONS-1:0];
      end
   end

   tpbd_prescaler u_slow (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .reload (cfg.second_reload),
      .fire   (slow_fire)
   );

   tpbd_prescaler u_fast (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .reload (cfg.fast_reload),
      .fire   (fast_fire)
   );

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_button
      tpbd_debounce #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_debounce (
         .clock           (clock),
         .reset           (reset),
         .step            (step),
         .level           (in_buttons_ff[b]),
         .count_limit     (cfg.count_limit),
         .press_threshold (cfg.press_threshold),
         .mark_next       (mark_next[b])
      );
   end

   always_comb begin
      out_data_in  = RSP_DATA_WIDTH'({mark_next, fast_fire, slow_fire});
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ design/tpbd_checker.sv @@
// ----------------------------------------------------------------------------
// tpbd_checker
// Port-level checks on the debounce core, bound to the top level.
// ----------------------------------------------------------------------------
module tpbd_checker
   import tpbd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                      csr_ready
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ##1 rsp_tvalid)
      else $error("request produced no response");

   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_WIDTH-1:NUM_BUTTONS+2] == '0))
      else $error("response padding not zero");

   a_csr_ready : assert property (@(posedge clock) disable iff (reset)
      csr_ready && $past(csr_ready))
      else $error("configuration port not ready");

endmodule

bind tick_prescaler_and_button_debounce_core tpbd_checker u_tpbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

@@ tb/tick_prescaler_and_button_debounce_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_prescaler_and_button_debounce_core_tb
// Drives timer ticks with button levels into the core and checks every
// response against a cycle-free model of the prescalers and the integrating
// debouncers, over several register settings and stall patterns.
// ----------------------------------------------------------------------------
module tick_prescaler_and_button_debounce_core_tb;
   import tpbd_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int COUNT_MAX    = (1 << COUNT_WIDTH_DEF) - 1;

   class debounce_predictor;
      logic [CFG_WIDTH-1:0] second_reload = SECOND_RELOAD_RST;
      logic [CFG_WIDTH-1:0] fast_reload = FAST_RELOAD_RST;
      logic [CFG_WIDTH-1:0] count_limit = COUNT_LIMIT_RST;
      logic [CFG_WIDTH-1:0] press_threshold = PRESS_THRESHOLD_RST;
      int                   slow_countdown = 0;
      int                   fast_countdown = 0;
      int                   press_count[NUM_BUTTONS] = '{0, 0, 0};
      logic                 pressed_mark[NUM_BUTTONS] = '{1'b0, 1'b0, 1'b0};
      logic [4:0]           expected_flags[$];
      string                field_name[5] = '{"slow_event", "fast_event", "pressed_one",
                                              "pressed_two", "pressed_three"};
      int                   errors = 0;
      int                   reported = 0;

      function void write_reg(reg_index_type idx, logic [CFG_WIDTH-1:0] value);
         case (idx)
            REG_SECOND_RELOAD:   second_reload = value;
            REG_FAST_RELOAD:     fast_reload = value;
            REG_COUNT_LIMIT:     count_limit = value;
            REG_PRESS_THRESHOLD: press_threshold = value;
            default: ;
         endcase
      endfunction

      function void note_tick(logic [2:0] levels);
         logic slow_ev;
         logic fast_ev;
         int   b;
         slow_ev = (slow_countdown <= 1);
         slow_countdown = slow_ev ? int'(second_reload) : slow_countdown - 1;
         fast_ev = (fast_countdown <= 1);
         fast_countdown = fast_ev ? int'(fast_reload) : fast_countdown - 1;
         for (b = 0; b < NUM_BUTTONS; b++) begin
            if (levels[b]) begin
               if (press_count[b] < int'(count_limit) && press_count[b] < COUNT_MAX) begin
                  press_count[b]++;
                  if (press_count[b] > int'(press_threshold))
                     pressed_mark[b] = 1'b1;
               end
            end else begin
               if (press_count[b] > 0)
                  press_count[b]--;
               if (press_count[b] == 0)
                  pressed_mark[b] = 1'b0;
            end
         end
         expected_flags.push_back({pressed_mark[2], pressed_mark[1], pressed_mark[0],
                                   fast_ev, slow_ev});
      endfunction

      function void report(string what);
         errors++;
         if (reported < 10) begin
            reported++;
            $display("mismatch: %s", what);
         end
      endfunction

      function void check_flags(logic [RSP_DATA_WIDTH-1:0] data);
         logic [4:0] want;
         int         f;
         if (expected_flags.size() == 0) begin
            report($sformatf("response %b with no request outstanding", data));
            return;
         end
         want = expected_flags.pop_front();
         for (f = 0; f < 5; f++) begin
            if (data[f] !== want[f])
               report($sformatf("%s expected %b, got %b", field_name[f], want[f], data[f]));
         end
      endfunction

      function int pending();
         return expected_flags.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // [0] button_one, [1] button_two, [2] button_three
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // [0] slow_event, [1] fast_event, [2] pressed_one, [3] pressed_two,
   // [4] pressed_three
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CFG_WIDTH-1:0]      csr_data;

   debounce_predictor sb = new();
   int                send_idle = 0;
   int                recv_idle = 0;
   int                hold_left = 0;
   int                cycles = 0;
   int                run_left[NUM_BUTTONS] = '{0, 0, 0};
   logic              run_level[NUM_BUTTONS] = '{1'b0, 1'b0, 1'b0};

   tick_prescaler_and_button_debounce_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: check, then pick next ready
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_flags(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic send_tick(input logic [2:0] levels);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_WIDTH-3){1'b0}}, levels};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(levels);
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      int            i;
      reg_index_type idx;
      csr_valid <= 1'b1;
      for (i = 0; i < 4; i++) begin
         idx = reg_index_type'(i);
         csr_index <= idx;
         case (idx)
            REG_SECOND_RELOAD:   csr_data <= c.second_reload;
            REG_FAST_RELOAD:     csr_data <= c.fast_reload;
            REG_COUNT_LIMIT:     csr_data <= c.count_limit;
            REG_PRESS_THRESHOLD: csr_data <= c.press_threshold;
            default: ;
         endcase
         do @(posedge clock); while (!csr_ready);
         case (idx)
            REG_SECOND_RELOAD:   sb.write_reg(idx, c.second_reload);
            REG_FAST_RELOAD:     sb.write_reg(idx, c.fast_reload);
            REG_COUNT_LIMIT:     sb.write_reg(idx, c.count_limit);
            REG_PRESS_THRESHOLD: sb.write_reg(idx, c.press_threshold);
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input cfg_type c, input int n, input bit with_hold,
                            input bit with_pause);
      int         k;
      int         b;
      int         max_run;
      logic [2:0] levels;
      wait_idle();
      apply_settings(c);
      max_run = int'(c.count_limit) + int'(c.press_threshold) + 4;
      for (k = 0; k < n; k++) begin
         if (with_hold && k == n / 3 && hold_left == 0)
            hold_left = 90;
         if (with_pause && k == n / 2) begin
            req_tvalid <= 1'b0;
            wait_idle();
         end
         if ($urandom_range(99) < 15) begin
            levels = 3'($urandom_range(7));
         end else begin
            for (b = 0; b < NUM_BUTTONS; b++) begin
               if (run_left[b] == 0) begin
                  run_level[b] = 1'($urandom_range(1));
                  run_left[b] = int'($urandom_range(max_run, 1));
               end
               run_left[b]--;
               levels[b] = run_level[b];
            end
         end
         send_tick(levels);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int         k;
      cfg_type    c;
      logic [7:0] lim;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_SECOND_RELOAD;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: both events on the first tick, all level patterns
      for (k = 0; k < 8; k++)
         send_tick(k[2:0]);
      req_tvalid <= 1'b0;

      // reload zero, small limit: counter saturates and holds, mark clears at zero
      wait_idle();
      apply_settings('{8'd0, 8'd1, 8'd4, 8'd1});
      for (k = 0; k < 6; k++)
         send_tick(3'b111);
      for (k = 0; k < 5; k++)
         send_tick(3'b000);
      req_tvalid <= 1'b0;

      // threshold not below limit: mark never set
      wait_idle();
      apply_settings('{8'd255, 8'd255, 8'd3, 8'd3});
      for (k = 0; k < 5; k++)
         send_tick(3'b111);
      req_tvalid <= 1'b0;

      send_idle = 22;
      recv_idle = 47;
      run_phase('{SECOND_RELOAD_RST, FAST_RELOAD_RST, COUNT_LIMIT_RST,
                  PRESS_THRESHOLD_RST}, 260, 1'b1, 1'b0);
      run_phase('{8'd1, 8'd1, 8'd1, 8'd0}, 260, 1'b0, 1'b0);

      send_idle = 47;
      recv_idle = 22;
      run_phase('{8'd255, 8'd255, 8'd255, 8'd254}, 260, 1'b0, 1'b1);
      lim = 8'($urandom_range(40, 1));
      c = '{8'($urandom_range(255, 1)), 8'($urandom_range(20, 1)), lim,
            8'($urandom_range(int'(lim) - 1, 0))};
      run_phase(c, 260, 1'b1, 1'b0);

      send_idle = 0;
      recv_idle = 0;
      run_phase('{8'd0, 8'd3, 8'd10, 8'd9}, 260, 1'b0, 1'b0);
      c = '{8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
            8'($urandom_range(255, 1)), 8'($urandom_range(254, 0))};
      run_phase(c, 260, 1'b0, 1'b0);

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
design/tpbd_pkg.sv
design/tpbd_csr.sv
design/tpbd_prescaler.sv
design/tpbd_debounce.sv
design/tick_prescaler_and_button_debounce_core.sv
design/tpbd_checker.sv
tb/tick_prescaler_and_button_debounce_core_tb.sv
